### rtl/a64rel_pkg.sv
// Package for the AArch64 relocation patcher: relocation kind codes,
// status codes, instruction field masks and the packed result type.
// No dependencies.
package a64rel_pkg;

	localparam int unsigned DATA_W   = 64;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned KIND_W   = 5;
	localparam int unsigned BYTES_W  = 4;
	localparam int unsigned STATUS_W = 2;

	// Input stream: action in tuser, five 64-bit fields in tdata.
	localparam int unsigned S_TDATA_W = 5 * DATA_W;
	localparam int unsigned S_TUSER_W = 8;
	// Output stream: 70 bits of fields, padded to whole bytes.
	localparam int unsigned M_TDATA_W = 72;

	typedef enum logic [KIND_W-1:0] {
		REL_ABS64        = 5'd0,
		REL_ABS32        = 5'd1,
		REL_PREL32       = 5'd2,
		REL_MOVW_G0      = 5'd3,
		REL_MOVW_G1      = 5'd4,
		REL_MOVW_G2      = 5'd5,
		REL_MOVW_G3      = 5'd6,
		REL_ADR_PG_HI21  = 5'd7,
		REL_ADD_LO12     = 5'd8,
		REL_LDST8_LO12   = 5'd9,
		REL_LDST16_LO12  = 5'd10,
		REL_LDST32_LO12  = 5'd11,
		REL_LDST64_LO12  = 5'd12,
		REL_LDST128_LO12 = 5'd13,
		REL_CONDBR19     = 5'd14,
		REL_TSTBR14      = 5'd15,
		REL_JUMP26       = 5'd16,
		REL_CALL26       = 5'd17,
		REL_ADR_GOT_PAGE = 5'd18,
		REL_LD64_GOT_LO12 = 5'd19,
		REL_COPY         = 5'd20,
		REL_GLOB_DAT     = 5'd21,
		REL_JUMP_SLOT    = 5'd22,
		REL_RELATIVE     = 5'd23
	} rel_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_RANGE       = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} rel_status_t;

	localparam logic [BYTES_W-1:0] WB_NONE  = 4'd0;
	localparam logic [BYTES_W-1:0] WB_WORD  = 4'd4;
	localparam logic [BYTES_W-1:0] WB_DWORD = 4'd8;

	localparam logic [WORD_W-1:0] MOVW_KEEP  = 32'hffe0001f;
	localparam logic [WORD_W-1:0] ADRP_KEEP  = 32'h9f00001f;
	localparam logic [WORD_W-1:0] LO12_KEEP  = 32'hffc003ff;
	localparam logic [WORD_W-1:0] BR19_KEEP  = 32'hff00001f;
	localparam logic [WORD_W-1:0] BR14_KEEP  = 32'hfff8001f;
	localparam logic [WORD_W-1:0] GOTLO_KEEP = 32'hfff803ff;
	localparam logic [WORD_W-1:0] B_OPCODE   = 32'h14000000;
	localparam logic [WORD_W-1:0] BL_BIT     = 32'h80000000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BYTES_W-1:0]  write_bytes;
		logic [DATA_W-1:0]   new_contents;
	} rel_result_t;

endpackage

### rtl/aarch64_relocation_patcher.sv
// AArch64 ELF relocation patcher: one relocation record in, one patched
// contents / byte count / status out. Depends on a64rel_pkg.
//
// Pipeline: a record is taken into the input register, and its result is registered in
// the result register, from which it is presented on the output.
// Throughput: one relocation per cycle while the output is not stalled; the patch logic
// is subtracts, add-and-mask range checks and field merges between the two registers.
// Reset: arst_n clears both stage valid flags; payload registers are not reset.
module aarch64_relocation_patcher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// old_contents[63:0], place_addr[127:64], sym_value[191:128],
	// got_entry_addr[255:192], addend[319:256]
	input  logic [a64rel_pkg::S_TDATA_W-1:0]     s_tdata,
	// action[4:0], zero padding above
	input  logic [a64rel_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// new_contents[63:0], write_bytes[67:64], status[69:68], zero padding above
	output logic [a64rel_pkg::M_TDATA_W-1:0]     m_tdata
);
	import a64rel_pkg::*;

	logic                valid_s1;
	logic [KIND_W-1:0]   action_s1;
	logic [DATA_W-1:0]   old_s1;
	logic [DATA_W-1:0]   place_s1;
	logic [DATA_W-1:0]   sym_s1;
	logic [DATA_W-1:0]   got_s1;
	logic [DATA_W-1:0]   addend_s1;

	logic                valid_s2;
	rel_result_t         result_s2;
	rel_result_t         result_d;

	logic                adv_s1;
	logic                take_in;

	// Stage 2 frees up when empty or drained this cycle; stage 1 likewise.
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= s_tuser[KIND_W-1:0];
			old_s1    <= s_tdata[0*DATA_W +: DATA_W];
			place_s1  <= s_tdata[1*DATA_W +: DATA_W];
			sym_s1    <= s_tdata[2*DATA_W +: DATA_W];
			got_s1    <= s_tdata[3*DATA_W +: DATA_W];
			addend_s1 <= s_tdata[4*DATA_W +: DATA_W];
		end
	end

	// Patch logic.
	always_comb begin
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] target;
		logic [DATA_W-1:0] off;
		logic [DATA_W-1:0] off_chk;
		logic [DATA_W-1:0] br_chk;
		logic              page_bad;
		logic              bad;

		w      = old_s1[WORD_W-1:0];
		d      = sym_s1 - place_s1;
		// ADRP via GOT pages the GOT slot instead of the symbol.
		target = (action_s1 == REL_ADR_GOT_PAGE) ? got_s1 : sym_s1;
		off    = {12'd0, target[DATA_W-1:12]} - {12'd0, place_s1[DATA_W-1:12]};
		off_chk  = off + (64'd1 << 20);
		page_bad = (off_chk[DATA_W-1:21] != '0);
		word   = (w & ADRP_KEEP) | {1'b0, off[1:0], 5'd0, off[20:2], 5'd0};
		bad    = 1'b0;
		br_chk = '0;

		result_d.new_contents = old_s1;
		result_d.write_bytes  = WB_WORD;
		result_d.status       = ST_OK;

		unique case (action_s1) inside
			REL_ABS64: begin
				result_d.new_contents = old_s1 + sym_s1;
				result_d.write_bytes  = WB_DWORD;
			end
			REL_ABS32:
				result_d.new_contents = {32'd0, w + sym_s1[WORD_W-1:0]};
			REL_PREL32:
				result_d.new_contents = {32'd0, w + d[WORD_W-1:0]};
			REL_MOVW_G0:
				result_d.new_contents = {32'd0, (w & MOVW_KEEP) | {11'd0, sym_s1[15:0], 5'd0}};
			REL_MOVW_G1:
				result_d.new_contents = {32'd0, (w & MOVW_KEEP) | {11'd0, sym_s1[31:16], 5'd0}};
			REL_MOVW_G2:
				result_d.new_contents = {32'd0, (w & MOVW_KEEP) | {11'd0, sym_s1[47:32], 5'd0}};
			REL_MOVW_G3:
				result_d.new_contents = {32'd0, (w & MOVW_KEEP) | {11'd0, sym_s1[63:48], 5'd0}};
			REL_ADR_PG_HI21, REL_ADR_GOT_PAGE: begin
				result_d.new_contents = {32'd0, word};
				bad = page_bad;
			end
			REL_ADD_LO12, REL_LDST8_LO12:
				result_d.new_contents = {32'd0, (w & LO12_KEEP) | {10'd0, sym_s1[11:0], 10'd0}};
			REL_LDST16_LO12:
				result_d.new_contents = {32'd0, (w & LO12_KEEP) | {11'd0, sym_s1[11:1], 10'd0}};
			REL_LDST32_LO12:
				result_d.new_contents = {32'd0, (w & LO12_KEEP) | {12'd0, sym_s1[11:2], 10'd0}};
			REL_LDST64_LO12:
				result_d.new_contents = {32'd0, (w & LO12_KEEP) | {13'd0, sym_s1[11:3], 10'd0}};
			REL_LDST128_LO12:
				result_d.new_contents = {32'd0, (w & LO12_KEEP) | {14'd0, sym_s1[11:4], 10'd0}};
			REL_CONDBR19: begin
				br_chk = d + (64'd1 << 20);
				bad = (br_chk[DATA_W-1:21] != '0) || (br_chk[1:0] != 2'd0);
				result_d.new_contents = {32'd0, (w & BR19_KEEP) | {8'd0, d[20:2], 5'd0}};
			end
			REL_TSTBR14: begin
				br_chk = d + (64'd1 << 15);
				bad = (br_chk[DATA_W-1:16] != '0) || (br_chk[1:0] != 2'd0);
				result_d.new_contents = {32'd0, (w & BR14_KEEP) | {13'd0, d[15:2], 5'd0}};
			end
			REL_JUMP26, REL_CALL26: begin
				br_chk = d + (64'd1 << 27);
				bad = (br_chk[DATA_W-1:28] != '0) || (br_chk[1:0] != 2'd0);
				result_d.new_contents = {32'd0, B_OPCODE |
					((action_s1 == REL_CALL26) ? BL_BIT : 32'd0) | {6'd0, d[27:2]}};
			end
			REL_LD64_GOT_LO12:
				result_d.new_contents = {32'd0, (w & GOTLO_KEEP) | {13'd0, got_s1[11:3], 10'd0}};
			REL_COPY, REL_RELATIVE:
				result_d.write_bytes = WB_NONE;
			REL_GLOB_DAT, REL_JUMP_SLOT: begin
				result_d.new_contents = sym_s1 - addend_s1;
				result_d.write_bytes  = WB_DWORD;
			end
			default: begin
				result_d.write_bytes = WB_NONE;
				result_d.status      = ST_UNSUPPORTED;
			end
		endcase

		if (bad) begin
			result_d.status = ST_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W - $bits(rel_result_t)){1'b0}}, result_s2};

	// A full pipeline with a stalled output must refuse new records.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input accepted while both stages are full and stalled");

	// An accepted record occupies the input stage on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted record lost from the input stage");

	// Unsupported kinds never request a store.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && result_s2.status == ST_UNSUPPORTED) |-> (result_s2.write_bytes == WB_NONE))
		else $error("store requested for an unsupported relocation");

	// Byte count is always none, a word or a doubleword.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_s2.write_bytes == WB_NONE || result_s2.write_bytes == WB_WORD ||
			result_s2.write_bytes == WB_DWORD))
		else $error("illegal write byte count");

endmodule

### tb/sv/aarch64_relocation_patcher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for aarch64_relocation_patcher: streams relocation records
// through the block and compares every patched result with a local prediction.
// Depends on a64rel_pkg and the aarch64_relocation_patcher RTL.
module aarch64_relocation_patcher_tb;
	import a64rel_pkg::*;

	localparam logic [KIND_W-1:0] FIRST_UNSUPPORTED = 5'd24;
	localparam logic [KIND_W-1:0] LAST_KIND         = 5'd31;
	localparam int unsigned RESULT_W = $bits(rel_result_t);

	// One relocation record, laid out so that {tuser kind, tdata} casts straight onto it.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] addend;
		logic [DATA_W-1:0] got_entry_addr;
		logic [DATA_W-1:0] sym_value;
		logic [DATA_W-1:0] place_addr;
		logic [DATA_W-1:0] old_contents;
	} reloc_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	reloc_t      pending_relocs[$];
	rel_result_t expected_patches[$];
	reloc_t      next_reloc;
	rel_result_t seen;
	rel_result_t want;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_off_left = 0;
	logic        offer_taken   = 1'b0;
	int unsigned queued_total    = 0;
	int unsigned accepted_total  = 0;
	int unsigned results_seen    = 0;
	int unsigned mismatch_count  = 0;
	int unsigned range_count     = 0;
	int unsigned unsupported_count = 0;
	int unsigned input_stall_cycles = 0;

	aarch64_relocation_patcher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Address within a random power-of-two distance of base, mostly word aligned.
	function automatic logic [DATA_W-1:0] near_addr(input logic [DATA_W-1:0] base);
		logic [DATA_W-1:0] delta;
		int unsigned span;
		span  = $urandom_range(34, 2);
		delta = rand64() & ((64'd1 << span) - 64'd1);
		if ($urandom_range(3) != 0)
			delta[1:0] = 2'b00;
		if ($urandom_range(1) != 0)
			delta = -delta;
		return base + delta;
	endfunction

	function automatic logic [WORD_W-1:0] page_word(input logic [WORD_W-1:0] w,
			input logic [DATA_W-1:0] target, input logic [DATA_W-1:0] place,
			output logic out_of_range);
		logic [DATA_W-1:0] pages;
		pages = (target >> 12) - (place >> 12);
		out_of_range = ((pages + 64'h10_0000) >> 21) != 64'd0;
		return (w & ADRP_KEEP) | {1'b0, pages[1:0], 5'd0, pages[20:2], 5'd0};
	endfunction

	// The low 12 bits are scaled down by the access size before landing at bit 10.
	function automatic logic [WORD_W-1:0] lo12_word(input logic [WORD_W-1:0] w,
			input logic [DATA_W-1:0] v, input int unsigned scale);
		logic [WORD_W-1:0] imm;
		imm = {20'd0, v[11:0]} >> scale;
		return (w & LO12_KEEP) | (imm << 10);
	endfunction

	function automatic logic [WORD_W-1:0] movw_word(input logic [WORD_W-1:0] w,
			input logic [15:0] imm16);
		return (w & MOVW_KEEP) | {11'd0, imm16, 5'd0};
	endfunction

	function automatic rel_result_t patch_reloc(input reloc_t r);
		rel_result_t       res;
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] disp;
		logic              out_of_range;
		w            = r.old_contents[WORD_W-1:0];
		disp         = r.sym_value - r.place_addr;
		out_of_range = 1'b0;
		word         = '0;
		res.new_contents = r.old_contents;
		res.write_bytes  = WB_WORD;
		res.status       = ST_OK;
		case (r.kind)
			REL_ABS64: begin
				res.new_contents = r.old_contents + r.sym_value;
				res.write_bytes  = WB_DWORD;
			end
			REL_ABS32:         word = w + r.sym_value[WORD_W-1:0];
			REL_PREL32:        word = w + disp[WORD_W-1:0];
			REL_MOVW_G0:       word = movw_word(w, r.sym_value[15:0]);
			REL_MOVW_G1:       word = movw_word(w, r.sym_value[31:16]);
			REL_MOVW_G2:       word = movw_word(w, r.sym_value[47:32]);
			REL_MOVW_G3:       word = movw_word(w, r.sym_value[63:48]);
			REL_ADR_PG_HI21:   word = page_word(w, r.sym_value, r.place_addr, out_of_range);
			REL_ADD_LO12,
			REL_LDST8_LO12:    word = lo12_word(w, r.sym_value, 0);
			REL_LDST16_LO12:   word = lo12_word(w, r.sym_value, 1);
			REL_LDST32_LO12:   word = lo12_word(w, r.sym_value, 2);
			REL_LDST64_LO12:   word = lo12_word(w, r.sym_value, 3);
			REL_LDST128_LO12:  word = lo12_word(w, r.sym_value, 4);
			REL_CONDBR19: begin
				out_of_range = ((disp + 64'h10_0000) & ~64'h1f_fffc) != 64'd0;
				word = (w & BR19_KEEP) | {8'd0, disp[20:2], 5'd0};
			end
			REL_TSTBR14: begin
				out_of_range = ((disp + 64'h8000) & ~64'hfffc) != 64'd0;
				word = (w & BR14_KEEP) | {13'd0, disp[15:2], 5'd0};
			end
			REL_JUMP26,
			REL_CALL26: begin
				out_of_range = ((disp + 64'h800_0000) & ~64'hfff_fffc) != 64'd0;
				word = B_OPCODE | {6'd0, disp[27:2]};
				if (r.kind == REL_CALL26)
					word = word | BL_BIT;
			end
			REL_ADR_GOT_PAGE:  word = page_word(w, r.got_entry_addr, r.place_addr,
				out_of_range);
			REL_LD64_GOT_LO12: word = (w & GOTLO_KEEP) | {13'd0, r.got_entry_addr[11:3], 10'd0};
			REL_COPY,
			REL_RELATIVE:      res.write_bytes = WB_NONE;
			REL_GLOB_DAT,
			REL_JUMP_SLOT: begin
				res.new_contents = r.sym_value - r.addend;
				res.write_bytes  = WB_DWORD;
			end
			default: begin
				res.write_bytes = WB_NONE;
				res.status      = ST_UNSUPPORTED;
			end
		endcase
		// Every word-sized patch is stored zero-extended.
		if (res.write_bytes == WB_WORD)
			res.new_contents = {32'd0, word};
		if (out_of_range)
			res.status = ST_RANGE;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got_v,
			input logic [DATA_W-1:0] want_v);
		$display("ERROR: result %0d, %s: got %0h, expected %0h", results_seen, what,
			got_v, want_v);
		mismatch_count++;
	endtask

	task automatic queue_reloc(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] old_v,
			input logic [DATA_W-1:0] place, input logic [DATA_W-1:0] sym,
			input logic [DATA_W-1:0] got, input logic [DATA_W-1:0] addend);
		reloc_t r;
		r.kind           = kind;
		r.old_contents   = old_v;
		r.place_addr     = place;
		r.sym_value      = sym;
		r.got_entry_addr = got;
		r.addend         = addend;
		pending_relocs.push_back(r);
		queued_total++;
	endtask

	// Mostly supported kinds, with targets often near the place so that both sides
	// of every range check get exercised.
	task automatic queue_random_reloc();
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] place;
		logic [DATA_W-1:0] sym;
		logic [DATA_W-1:0] got;
		if ($urandom_range(9) == 0)
			kind = KIND_W'($urandom_range(LAST_KIND, FIRST_UNSUPPORTED));
		else
			kind = KIND_W'($urandom_range(REL_RELATIVE, REL_ABS64));
		place = rand64();
		sym   = ($urandom_range(3) != 0) ? near_addr(place) : rand64();
		got   = ($urandom_range(3) != 0) ? near_addr(place) : rand64();
		queue_reloc(kind, rand64(), place, sym, got, rand64());
	endtask

	task automatic drain();
		while (accepted_total != queued_total || expected_patches.size() != 0)
			@(negedge clk);
	endtask

	// Sender: presents a new record once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || offer_taken)) begin
			offer_taken = 1'b0;
			if (pending_relocs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_reloc = pending_relocs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {next_reloc.addend, next_reloc.got_entry_addr,
					next_reloc.sym_value, next_reloc.place_addr, next_reloc.old_contents};
				s_tuser  <= {{(S_TUSER_W-KIND_W){1'b0}}, next_reloc.kind};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_left != 0) begin
				m_tready <= 1'b0;
				hold_off_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[RESULT_W-1:0];
				if (expected_patches.size() == 0) begin
					report_mismatch("unexpected transaction", seen.new_contents, '0);
				end else begin
					want = expected_patches.pop_front();
					if (seen.new_contents !== want.new_contents)
						report_mismatch("new_contents", seen.new_contents, want.new_contents);
					if (seen.write_bytes !== want.write_bytes)
						report_mismatch("write_bytes", DATA_W'(seen.write_bytes),
							DATA_W'(want.write_bytes));
					if (seen.status !== want.status)
						report_mismatch("status", DATA_W'(seen.status), DATA_W'(want.status));
					if (want.status == ST_RANGE)
						range_count++;
					if (want.status == ST_UNSUPPORTED)
						unsupported_count++;
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				expected_patches.push_back(patch_reloc(reloc_t'({s_tuser[KIND_W-1:0], s_tdata})));
				accepted_total++;
				offer_taken = 1'b1;
			end
			if (s_tvalid && !s_tready)
				input_stall_cycles++;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 54;
		// Wrap-around data adds, each MOVW group, page offsets at the edge of range and each LO12 scaling.
		queue_reloc(REL_ABS64, '1, rand64(), 64'd1, rand64(), rand64());
		queue_reloc(REL_ABS32, 64'hdead_beef_ffff_fff0, rand64(), 64'h20, rand64(), rand64());
		queue_reloc(REL_PREL32, '0, 64'h1000, 64'h800, rand64(), rand64());
		queue_reloc(REL_MOVW_G0, '1, rand64(), 64'h1234_5678_9abc_def0, rand64(), rand64());
		queue_reloc(REL_MOVW_G1, '0, rand64(), 64'h1234_5678_9abc_def0, rand64(), rand64());
		queue_reloc(REL_MOVW_G2, '1, rand64(), 64'h1234_5678_9abc_def0, rand64(), rand64());
		queue_reloc(REL_MOVW_G3, '0, rand64(), '1, rand64(), rand64());
		queue_reloc(REL_ADR_PG_HI21, '1, 64'h40_1234, 64'h1_0040_0000, rand64(), rand64());
		queue_reloc(REL_ADR_PG_HI21, '0, 64'h40_1234, 64'h1_0040_1234, rand64(), rand64());
		queue_reloc(REL_ADD_LO12, '0, rand64(), '1, rand64(), rand64());
		queue_reloc(REL_LDST8_LO12, '1, rand64(), 64'habc, rand64(), rand64());
		queue_reloc(REL_LDST16_LO12, '0, rand64(), 64'hfff, rand64(), rand64());
		queue_reloc(REL_LDST32_LO12, '1, rand64(), 64'hfff, rand64(), rand64());
		queue_reloc(REL_LDST64_LO12, '0, rand64(), 64'hfff, rand64(), rand64());
		queue_reloc(REL_LDST128_LO12, '1, rand64(), 64'hfff, rand64(), rand64());
		// Branch displacements right at the limits, one misaligned, one wrapping below zero.
		queue_reloc(REL_CONDBR19, '1, 64'h1000, 64'h1000 + 64'hf_fffc, rand64(), rand64());
		queue_reloc(REL_TSTBR14, '0, 64'h1_0000, 64'h1_0000 - 64'h8000, rand64(), rand64());
		queue_reloc(REL_TSTBR14, '1, 64'h1_0000, 64'h1_0002, rand64(), rand64());
		queue_reloc(REL_JUMP26, '1, 64'h2000, 64'h2000 + 64'h7ff_fffc, rand64(), rand64());
		queue_reloc(REL_CALL26, '0, '0, -64'h800_0004, rand64(), rand64());
		queue_reloc(REL_ADR_GOT_PAGE, '1, '1, rand64(), '0, rand64());
		queue_reloc(REL_LD64_GOT_LO12, '0, rand64(), rand64(), '1, rand64());
		queue_reloc(REL_COPY, 64'h0123_4567_89ab_cdef, rand64(), rand64(), rand64(), rand64());
		queue_reloc(REL_GLOB_DAT, rand64(), rand64(), '0, rand64(), 64'd1);
		queue_reloc(REL_JUMP_SLOT, rand64(), rand64(), '1, rand64(), '1);
		queue_reloc(REL_RELATIVE, '1, rand64(), rand64(), rand64(), rand64());
		queue_reloc(FIRST_UNSUPPORTED, 64'hfeed_face_cafe_f00d, rand64(), rand64(), rand64(),
			rand64());
		queue_reloc(LAST_KIND, '1, rand64(), rand64(), rand64(), rand64());
		repeat (130) queue_random_reloc();
		drain();

		send_idle_pct = 54;
		recv_idle_pct = 18;
		repeat (135) queue_random_reloc();
		drain();

		// No idling, except one long receiver hold-off while the sender keeps offering.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_off_left = 200;
		repeat (135) queue_random_reloc();
		drain();

		repeat (10) @(posedge clk);
		$display("Checked %0d relocations over all kinds: %0d out of range, %0d unsupported.",
			results_seen, range_count, unsupported_count);
		$display("The input was held off for %0d cycles by output back-pressure.",
			input_stall_cycles);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout: %0d of %0d transactions accepted, %0d results still due.",
			accepted_total, queued_total, expected_patches.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
